// ----- rtl/core/ebaf_pkg.sv -----
// Shared constants, types and helper functions of the event background activity filter.
package ebaf_pkg;

	// Map geometry and field widths.
	localparam int MAP_WIDTH   = 256;
	localparam int MAP_HEIGHT  = 256;
	localparam int TIME_W      = 63;
	localparam int COORD_W     = 8;
	localparam int DELTA_W     = 31;
	localparam int SHIFT_W     = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = DELTA_W;

	localparam int IN_TDATA_W  = ((TIME_W + 2 * COORD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	// The map is split into nine banks by column and row modulo three, so that the
	// nine cells of any neighbourhood fall into nine different banks.
	localparam int BANKS      = 9;
	localparam int BANK_IDX_W = $clog2(BANKS);
	localparam int BANK_COLS  = (MAP_WIDTH + 2) / 3;
	localparam int BANK_ROWS  = (MAP_HEIGHT + 2) / 3;
	localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
	localparam int QXW        = (BANK_COLS > 1) ? $clog2(BANK_COLS) : 1;
	localparam int QYW        = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
	localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	// Division by three of a coordinate: multiply by the reciprocal and shift.
	// Exact for every value of COORD_W bits.
	localparam int RECIP3       = 171;
	localparam int RECIP3_SHIFT = 9;

	// Reset values of the configuration registers.
	localparam logic [DELTA_W-1:0] DELTA_T_RESET     = DELTA_W'(30000);
	localparam logic [SHIFT_W-1:0] SHIFT_RESET       = '0;
	localparam logic [COORD_W-1:0] LAST_COLUMN_RESET = COORD_W'(255);
	localparam logic [COORD_W-1:0] LAST_ROW_RESET    = COORD_W'(255);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DELTA_T     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SHIFT       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LAST_COLUMN = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LAST_ROW    = 2'd3;

	// Position of a bank relative to the centre cell along one axis.
	typedef enum logic [1:0] {
		OFF_MID   = 2'd0,
		OFF_PLUS  = 2'd1,
		OFF_MINUS = 2'd2
	} off_t;

	typedef struct packed {
		logic [COORD_W-1:0] q;
		logic [1:0]         r;
	} div3_t;

	function automatic div3_t div3(input logic [COORD_W-1:0] v);
		logic [2*COORD_W-1:0] p;
		logic [COORD_W-1:0]   q;
		logic [COORD_W-1:0]   rem;
		div3_t                res;
		p     = (2 * COORD_W)'(v) * (2 * COORD_W)'(RECIP3);
		q     = COORD_W'(p >> RECIP3_SHIFT);
		rem   = v - (q << 1) - q;
		res.q = q;
		res.r = rem[1:0];
		return res;
	endfunction

	function automatic off_t bank_offset(input logic [1:0] bank, input logic [1:0] r);
		logic [1:0] r_next;
		off_t       res;
		r_next = (r == 2'd2) ? 2'd0 : r + 2'd1;
		if (bank == r) begin
			res = OFF_MID;
		end else if (bank == r_next) begin
			res = OFF_PLUS;
		end else begin
			res = OFF_MINUS;
		end
		return res;
	endfunction

	function automatic logic [AW-1:0] bank_addr(input logic [QXW-1:0] qc,
			input logic [QYW-1:0] qr);
		return AW'(BANK_ROWS * int'(qc) + int'(qr));
	endfunction

endpackage

// ----- rtl/core/ebaf_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module ebaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// The read data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/event_background_activity_filter.sv -----
// Top level of the event background activity filter: nine-bank timestamp map and pipeline.
//
//   channel  direction  handshake                      payload
//   s_axis   in         s_axis_tvalid / s_axis_tready  event_time, event_x, event_y
//   m_axis   out        m_axis_tvalid / m_axis_tready  keep
//   cfg      in         cfg_we (no wait)               cfg_index, cfg_data
//
// One item per cycle sustained while m_axis_tready is high and the clearing pass is over;
// each of the nine map banks has one read and one write port, and an item uses at most
// one of them in each bank. The result passes through stage 1, stage 2 and the output
// register to m_axis. After reset a clearing pass writes zero to all BANK_DEPTH
// addresses of the banks (7396 for a 256 by 256 map); no item is accepted until it ends.
// With m_axis_tready low an item holds once the stages after it are full; but for the
// clearing pass, the map is written only when an item leaves the first stage, so a
// stall never repeats or loses a write.
module event_background_activity_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// event_time [62:0], event_x [70:63], event_y [78:71], zero [79]
	input  logic [ebaf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// keep [0], zero [7:1]
	output logic [ebaf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [ebaf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ebaf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Configuration registers.
	logic [ebaf_pkg::DELTA_W-1:0] delta_t_q;
	logic [ebaf_pkg::SHIFT_W-1:0] subsample_shift_q;
	logic [ebaf_pkg::COORD_W-1:0] last_column_q;
	logic [ebaf_pkg::COORD_W-1:0] last_row_q;

	// Clearing pass.
	logic                    clr_active_q;
	logic [ebaf_pkg::AW-1:0] clr_addr_q;

	// Handshake and pipeline control.
	logic in_fire;
	logic out_ready;
	logic s1_adv;
	logic s1_go;

	// Input decode.
	logic [ebaf_pkg::TIME_W-1:0]  in_time;
	logic [ebaf_pkg::COORD_W-1:0] in_xs;
	logic [ebaf_pkg::COORD_W-1:0] in_ys;
	ebaf_pkg::div3_t              in_dx;
	ebaf_pkg::div3_t              in_dy;

	// Stage 1: map access.
	logic                         valid_s1;
	logic [ebaf_pkg::TIME_W-1:0]  t_s1;
	logic [ebaf_pkg::COORD_W-1:0] x_s1;
	logic [ebaf_pkg::COORD_W-1:0] y_s1;
	logic [ebaf_pkg::QXW-1:0]     qx_s1;
	logic [ebaf_pkg::QYW-1:0]     qy_s1;
	logic [1:0]                   rx_s1;
	logic [1:0]                   ry_s1;

	logic [ebaf_pkg::COORD_W-1:0] lc_eff;
	logic [ebaf_pkg::COORD_W-1:0] lr_eff;
	logic                         in_map_s1;
	logic                         x_minus_ok;
	logic                         x_plus_ok;
	logic                         y_minus_ok;
	logic                         y_plus_ok;
	logic [ebaf_pkg::AW-1:0]      centre_addr;

	// Stage 2: decision.
	logic                            valid_s2;
	logic [ebaf_pkg::TIME_W-1:0]     t_s2;
	logic                            in_map_s2;
	logic [ebaf_pkg::BANK_IDX_W-1:0] bank_s2;
	logic [ebaf_pkg::TIME_W-1:0]     stored_s2;
	logic [ebaf_pkg::TIME_W:0]       diff_s2;
	logic                            keep_s2;

	// Output register.
	logic out_valid_q;
	logic keep_q;

	// Bank ports.
	logic [ebaf_pkg::BANKS-1:0]  bank_wr_en;
	logic [ebaf_pkg::BANKS-1:0]  bank_rd_en;
	logic [ebaf_pkg::AW-1:0]     bank_wr_addr [ebaf_pkg::BANKS];
	logic [ebaf_pkg::TIME_W-1:0] bank_wr_data [ebaf_pkg::BANKS];
	logic [ebaf_pkg::TIME_W-1:0] bank_rd_data [ebaf_pkg::BANKS];

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_t_q         <= ebaf_pkg::DELTA_T_RESET;
			subsample_shift_q <= ebaf_pkg::SHIFT_RESET;
			last_column_q     <= ebaf_pkg::LAST_COLUMN_RESET;
			last_row_q        <= ebaf_pkg::LAST_ROW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ebaf_pkg::REG_DELTA_T: begin
					delta_t_q <= cfg_data[ebaf_pkg::DELTA_W-1:0];
				end
				ebaf_pkg::REG_SHIFT: begin
					subsample_shift_q <= cfg_data[ebaf_pkg::SHIFT_W-1:0];
				end
				ebaf_pkg::REG_LAST_COLUMN: begin
					last_column_q <= cfg_data[ebaf_pkg::COORD_W-1:0];
				end
				ebaf_pkg::REG_LAST_ROW: begin
					last_row_q <= cfg_data[ebaf_pkg::COORD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == ebaf_pkg::AW'(ebaf_pkg::BANK_DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s1_adv        = !valid_s2 || out_ready;
	assign s1_go         = valid_s1 && s1_adv;
	assign s_axis_tready = !clr_active_q && (!valid_s1 || s1_adv);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign in_time = s_axis_tdata[ebaf_pkg::TIME_W-1:0];
	assign in_xs   = s_axis_tdata[ebaf_pkg::TIME_W +: ebaf_pkg::COORD_W] >> subsample_shift_q;
	assign in_ys   = s_axis_tdata[ebaf_pkg::TIME_W + ebaf_pkg::COORD_W +: ebaf_pkg::COORD_W]
		>> subsample_shift_q;
	assign in_dx   = ebaf_pkg::div3(in_xs);
	assign in_dy   = ebaf_pkg::div3(in_ys);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			t_s1  <= in_time;
			x_s1  <= in_xs;
			y_s1  <= in_ys;
			qx_s1 <= ebaf_pkg::QXW'(in_dx.q);
			qy_s1 <= ebaf_pkg::QYW'(in_dy.q);
			rx_s1 <= in_dx.r;
			ry_s1 <= in_dy.r;
		end
	end

	// Map bounds are limited to the size of the store.
	always_comb begin
		lc_eff = (32'(last_column_q) > ebaf_pkg::MAP_WIDTH - 1)
			? ebaf_pkg::COORD_W'(ebaf_pkg::MAP_WIDTH - 1) : last_column_q;
		lr_eff = (32'(last_row_q) > ebaf_pkg::MAP_HEIGHT - 1)
			? ebaf_pkg::COORD_W'(ebaf_pkg::MAP_HEIGHT - 1) : last_row_q;
	end

	assign in_map_s1   = (x_s1 <= lc_eff) && (y_s1 <= lr_eff);
	assign x_minus_ok  = x_s1 != '0;
	assign x_plus_ok   = x_s1 < lc_eff;
	assign y_minus_ok  = y_s1 != '0;
	assign y_plus_ok   = y_s1 < lr_eff;
	assign centre_addr = ebaf_pkg::bank_addr(qx_s1, qy_s1);

	// Each bank sees either the centre read or one neighbour write of the item in
	// stage 1. A later item reads only after this write edge, so no forwarding is needed.
	for (genvar gc = 0; gc < 3; gc++) begin : g_col
		for (genvar gr = 0; gr < 3; gr++) begin : g_row
			localparam int K = gc * 3 + gr;

			ebaf_pkg::off_t           ox;
			ebaf_pkg::off_t           oy;
			logic [ebaf_pkg::QXW-1:0] qc;
			logic [ebaf_pkg::QYW-1:0] qr;
			logic                     nb_ok;

			always_comb begin
				ox = ebaf_pkg::bank_offset(2'(gc), rx_s1);
				oy = ebaf_pkg::bank_offset(2'(gr), ry_s1);
				case (ox)
					ebaf_pkg::OFF_PLUS:  qc = qx_s1 + ebaf_pkg::QXW'(rx_s1 == 2'd2);
					ebaf_pkg::OFF_MINUS: qc = qx_s1 - ebaf_pkg::QXW'(rx_s1 == 2'd0);
					default:             qc = qx_s1;
				endcase
				case (oy)
					ebaf_pkg::OFF_PLUS:  qr = qy_s1 + ebaf_pkg::QYW'(ry_s1 == 2'd2);
					ebaf_pkg::OFF_MINUS: qr = qy_s1 - ebaf_pkg::QYW'(ry_s1 == 2'd0);
					default:             qr = qy_s1;
				endcase
				nb_ok = !(ox == ebaf_pkg::OFF_MID && oy == ebaf_pkg::OFF_MID)
					&& (ox != ebaf_pkg::OFF_MINUS || x_minus_ok)
					&& (ox != ebaf_pkg::OFF_PLUS || x_plus_ok)
					&& (oy != ebaf_pkg::OFF_MINUS || y_minus_ok)
					&& (oy != ebaf_pkg::OFF_PLUS || y_plus_ok);

				bank_wr_en[K]   = clr_active_q || (s1_go && in_map_s1 && nb_ok);
				bank_wr_addr[K] = clr_active_q ? clr_addr_q : ebaf_pkg::bank_addr(qc, qr);
				bank_wr_data[K] = clr_active_q ? '0 : t_s1;
				bank_rd_en[K]   = s1_go && in_map_s1
					&& ox == ebaf_pkg::OFF_MID && oy == ebaf_pkg::OFF_MID;
			end

			ebaf_ram #(
				.WIDTH(ebaf_pkg::TIME_W),
				.DEPTH(ebaf_pkg::BANK_DEPTH)
			) u_bank (
				.clk     (clk),
				.wr_en   (bank_wr_en[K]),
				.wr_addr (bank_wr_addr[K]),
				.wr_data (bank_wr_data[K]),
				.rd_en   (bank_rd_en[K]),
				.rd_addr (centre_addr),
				.rd_data (bank_rd_data[K])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			t_s2      <= t_s1;
			in_map_s2 <= in_map_s1;
			bank_s2   <= ebaf_pkg::BANK_IDX_W'(rx_s1) * ebaf_pkg::BANK_IDX_W'(3)
				+ ebaf_pkg::BANK_IDX_W'(ry_s1);
		end
	end

	// The difference is read as a signed value: a negative one always lies inside the window.
	always_comb begin
		stored_s2 = bank_rd_data[bank_s2];
		diff_s2   = {1'b0, t_s2} - {1'b0, stored_s2};
		keep_s2   = in_map_s2 && (stored_s2 != '0)
			&& (diff_s2[ebaf_pkg::TIME_W]
			|| diff_s2 < (ebaf_pkg::TIME_W + 1)'(delta_t_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			keep_q <= keep_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = ebaf_pkg::OUT_TDATA_W'(keep_q);

	// Only the centre bank of one item is read in a cycle.
	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_rd_en))
		else $error("more than one bank read in a cycle");

	// The centre cell is never written by its own item.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_rd_en & bank_wr_en) == '0)
		else $error("bank read and written in the same cycle");

	// At most the eight neighbours are written outside the clearing pass.
	a_eight_writes: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_active_q |-> $countones(bank_wr_en) <= 8)
		else $error("more than eight neighbour writes");

	// No item reaches the decision stage while the map is still being cleared.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !valid_s1 && !valid_s2 && !out_valid_q)
		else $error("item in flight during clearing pass");

endmodule
